// ----- rtl/plnr_pkg.sv -----
// Shared constants, register indexes and inter-module types for the
// periodic lattice neighbor row generator. No dependencies.
package plnr_pkg;

   localparam int MAX_DIMS     = 4;
   localparam int SITE_BITS    = 20;
   localparam int POT_BITS     = 16;
   localparam int SIDE_BITS    = 11;
   localparam int COORD_BITS   = 10;
   localparam int DIM_BITS     = 3;
   localparam int SLOT_BITS    = 4;
   localparam int ROW_END_BITS = 24;
   localparam int SIDE_MAX     = 1024;

   localparam int DIM_IDX_BITS     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int STEPS_PER_STAGE  = 4;
   localparam int STAGES_PER_DIGIT = (SITE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int DIV_BITS         = STAGES_PER_DIGIT * STEPS_PER_STAGE;
   localparam int DIV_STAGES       = STAGES_PER_DIGIT * MAX_DIMS;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIMENSION_COUNT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIDE_LENGTH     = 1'd1;

   localparam logic [DIM_BITS-1:0]  DIMS_RESET = 3'd1;
   localparam logic [SIDE_BITS-1:0] SIDE_RESET = 11'd16;

   localparam logic signed [POT_BITS-1:0] HOP_VALUE = -16'sd4096;

   typedef struct packed {
      logic [DIM_BITS-1:0]                  dims;
      logic [SIDE_BITS-1:0]                 side;
      logic [MAX_DIMS-1:0][SITE_BITS-1:0]   weight;
      logic [MAX_DIMS-1:0][SITE_BITS-1:0]   wrap;
   } cfg_type;

   typedef struct packed {
      logic [SITE_BITS-1:0]                 site;
      logic signed [POT_BITS-1:0]           potential;
      logic [MAX_DIMS-1:0][COORD_BITS-1:0]  coord;
      logic                                 bad;
   } coord_type;

   typedef struct packed {
      logic [SITE_BITS-1:0]                 site;
      logic [SITE_BITS-1:0]                 base;
      logic signed [POT_BITS-1:0]           potential;
      logic [MAX_DIMS-1:0]                  at_low;
      logic [MAX_DIMS-1:0]                  at_high;
      logic [ROW_END_BITS-1:0]              row_end;
      logic                                 bad;
   } item_type;

endpackage

// ----- rtl/plnr_config.sv -----
// Configuration registers with clamping, plus the per-dimension weights and
// wrap offsets derived from them. Depends on plnr_pkg.
module plnr_config (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [plnr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [plnr_pkg::SIDE_BITS-1:0]       csr_data,
   output plnr_pkg::cfg_type                    cfg
);
   import plnr_pkg::*;

   localparam int PROD_BITS = SITE_BITS + SIDE_BITS;

   logic [DIM_BITS-1:0]  dims_ff;
   logic [SIDE_BITS-1:0] side_ff;
   logic [DIM_BITS-1:0]  dims_in;
   logic [SIDE_BITS-1:0] side_in;
   logic [SITE_BITS-1:0] weight_ff [MAX_DIMS+1];
   logic [SITE_BITS-1:0] weight_in [MAX_DIMS+1];
   logic [SITE_BITS-1:0] wrap_ff [MAX_DIMS];
   logic [SITE_BITS-1:0] wrap_in [MAX_DIMS];

   always_comb begin
      logic [DIM_BITS-1:0]  dv;
      logic [SIDE_BITS-1:0] sv;
      logic [PROD_BITS-1:0] prod;
      dims_in = dims_ff;
      side_in = side_ff;
      dv = csr_data[DIM_BITS-1:0];
      sv = csr_data;
      if (csr_write) begin
         case (csr_index)
            CSR_DIMENSION_COUNT: begin
               if (dv == '0) begin
                  dims_in = DIM_BITS'(1);
               end else if (dv > DIM_BITS'(MAX_DIMS)) begin
                  dims_in = DIM_BITS'(MAX_DIMS);
               end else begin
                  dims_in = dv;
               end
            end
            CSR_SIDE_LENGTH: begin
               if (sv == '0) begin
                  side_in = SIDE_BITS'(1);
               end else if (sv > SIDE_BITS'(SIDE_MAX)) begin
                  side_in = SIDE_BITS'(SIDE_MAX);
               end else begin
                  side_in = sv;
               end
            end
            default: begin
            end
         endcase
      end
      weight_in[0] = SITE_BITS'(1);
      for (int k = 1; k <= MAX_DIMS; k++) begin
         prod = PROD_BITS'(weight_ff[k-1]) * PROD_BITS'(side_ff);
         weight_in[k] = prod[SITE_BITS-1:0];
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
         wrap_in[d] = weight_ff[d+1] - weight_ff[d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_RESET;
         side_ff <= SIDE_RESET;
      end else begin
         dims_ff <= dims_in;
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      weight_ff <= weight_in;
      wrap_ff   <= wrap_in;
   end

   always_comb begin
      cfg.dims = dims_ff;
      cfg.side = side_ff;
      for (int d = 0; d < MAX_DIMS; d++) begin
         cfg.weight[d] = weight_ff[d];
         cfg.wrap[d]   = wrap_ff[d];
      end
   end

endmodule

// ----- rtl/plnr_divider.sv -----
// Pipelined restoring divider that splits a site index into its mixed-radix
// coordinates, a few quotient bits per stage. Depends on plnr_pkg.
module plnr_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               req_valid,
   input  logic [plnr_pkg::SITE_BITS-1:0]     req_site,
   input  logic signed [plnr_pkg::POT_BITS-1:0] req_potential,
   input  plnr_pkg::cfg_type                  cfg,
   output logic                               out_valid,
   output plnr_pkg::coord_type                out_item
);
   import plnr_pkg::*;

   typedef struct packed {
      logic [SITE_BITS-1:0]                 site;
      logic signed [POT_BITS-1:0]           potential;
      logic [DIV_BITS-1:0]                  num;
      logic [COORD_BITS-1:0]                rem;
      logic [MAX_DIMS-1:0][COORD_BITS-1:0]  coord;
      logic                                 bad;
   } div_stage_type;

   logic [DIV_STAGES-1:0] valid_ff;
   div_stage_type         stage_ff [DIV_STAGES];
   div_stage_type         stage_in [DIV_STAGES];
   div_stage_type         first;

   always_comb begin
      first.site      = req_site;
      first.potential = req_potential;
      first.num       = DIV_BITS'(req_site);
      first.rem       = '0;
      first.coord     = '0;
      first.bad       = 1'b0;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int  DIGIT = k / STAGES_PER_DIGIT;
      localparam bit  LAST  = (k % STAGES_PER_DIGIT) == (STAGES_PER_DIGIT - 1);
      div_stage_type src;

      if (k == 0) begin : g_head
         assign src = first;
      end else begin : g_body
         assign src = stage_ff[k-1];
      end

      always_comb begin
         logic [DIV_BITS-1:0]   n;
         logic [COORD_BITS-1:0] r;
         logic [COORD_BITS:0]   t;
         n = src.num;
         r = src.rem;
         for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            t = {r, n[DIV_BITS-1]};
            n = {n[DIV_BITS-2:0], 1'b0};
            if (t >= cfg.side) begin
               t    = t - cfg.side;
               n[0] = 1'b1;
            end
            r = t[COORD_BITS-1:0];
         end
         stage_in[k]     = src;
         stage_in[k].num = n;
         stage_in[k].rem = r;
         if (LAST) begin
            stage_in[k].coord[DIGIT] = r;
            stage_in[k].rem          = '0;
            if (DIM_BITS'(DIGIT + 1) == cfg.dims) begin
               stage_in[k].bad = (n != '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      out_valid          = valid_ff[DIV_STAGES-1];
      out_item.site      = stage_ff[DIV_STAGES-1].site;
      out_item.potential = stage_ff[DIV_STAGES-1].potential;
      out_item.coord     = stage_ff[DIV_STAGES-1].coord;
      out_item.bad       = stage_ff[DIV_STAGES-1].bad;
   end

endmodule

// ----- rtl/plnr_compose.sv -----
// Multiply-accumulate stages that rebuild the in-lattice base index from the
// coordinates, plus boundary flags and the row end offset. Depends on plnr_pkg.
module plnr_compose (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  plnr_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   input  plnr_pkg::coord_type  in_item,
   output logic                 out_valid,
   output plnr_pkg::item_type   out_item
);
   import plnr_pkg::*;

   localparam int PROD_BITS = COORD_BITS + SITE_BITS;

   typedef struct packed {
      coord_type            item;
      logic [SITE_BITS-1:0] acc;
      logic [SITE_BITS-1:0] prod;
   } mac_type;

   logic [MAX_DIMS:0] valid_ff;
   mac_type           mac_ff [MAX_DIMS];
   mac_type           mac_in [MAX_DIMS];
   item_type          item_ff;
   item_type          item_in;

   always_comb begin
      logic [PROD_BITS-1:0] p;
      for (int j = 0; j < MAX_DIMS; j++) begin
         if (j == 0) begin
            mac_in[j].item = in_item;
            mac_in[j].acc  = '0;
         end else begin
            mac_in[j].item = mac_ff[j-1].item;
            mac_in[j].acc  = mac_ff[j-1].acc + mac_ff[j-1].prod;
         end
         p = PROD_BITS'(mac_in[j].item.coord[j]) * PROD_BITS'(cfg.weight[j]);
         if (DIM_BITS'(j) < cfg.dims) begin
            mac_in[j].prod = p[SITE_BITS-1:0];
         end else begin
            mac_in[j].prod = '0;
         end
      end
   end

   always_comb begin
      logic [ROW_END_BITS-1:0] site_inc;
      logic [SLOT_BITS-1:0]    count;
      coord_type               src;
      src = mac_ff[MAX_DIMS-1].item;
      site_inc = ROW_END_BITS'(src.site) + ROW_END_BITS'(1);
      count = {cfg.dims, 1'b1};
      item_in.site      = src.site;
      item_in.base      = mac_ff[MAX_DIMS-1].acc + mac_ff[MAX_DIMS-1].prod;
      item_in.potential = src.potential;
      item_in.bad       = src.bad;
      item_in.row_end   = site_inc * ROW_END_BITS'(count);
      for (int d = 0; d < MAX_DIMS; d++) begin
         item_in.at_low[d]  = (src.coord[d] == '0);
         item_in.at_high[d] = ({1'b0, src.coord[d]} == (cfg.side - SIDE_BITS'(1)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[MAX_DIMS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mac_ff  <= mac_in;
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff[MAX_DIMS];
   assign out_item  = item_ff;

endmodule

// ----- rtl/plnr_emitter.sv -----
// Row serializer: holds one site and walks its slots, forming one row column
// per cycle while the response is not stalled, into the response register. Depends on plnr_pkg.
module plnr_emitter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  plnr_pkg::cfg_type                      cfg,
   input  logic                                   in_valid,
   input  plnr_pkg::item_type                     in_item,
   output logic                                   advance,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [plnr_pkg::SITE_BITS-1:0]         rsp_column,
   output logic signed [plnr_pkg::POT_BITS-1:0]   rsp_entry_value,
   output logic [plnr_pkg::SLOT_BITS-1:0]         rsp_slot,
   output logic [plnr_pkg::ROW_END_BITS-1:0]      rsp_row_end,
   output logic                                   rsp_last,
   output logic                                   rsp_bad_site
);
   import plnr_pkg::*;

   item_type                   cur_ff;
   logic                       cur_valid_ff;
   logic [SLOT_BITS-1:0]       slot_ff;
   logic                       rsp_valid_ff;
   logic [SITE_BITS-1:0]       column_ff;
   logic signed [POT_BITS-1:0] value_ff;
   logic [SLOT_BITS-1:0]       rsp_slot_ff;
   logic [ROW_END_BITS-1:0]    row_end_ff;
   logic                       last_ff;
   logic                       bad_ff;

   logic                       out_load;
   logic                       cur_last;
   logic                       take;
   logic [SLOT_BITS-1:0]       slot_m1;
   logic [DIM_IDX_BITS-1:0]    dim;
   logic [SITE_BITS-1:0]       column_in;
   logic signed [POT_BITS-1:0] value_in;

   assign out_load = cur_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign cur_last = (slot_ff == {cfg.dims, 1'b0});
   assign take     = !cur_valid_ff || (out_load && cur_last);
   assign advance  = !in_valid || take;
   assign slot_m1  = slot_ff - SLOT_BITS'(1);
   assign dim      = slot_m1[DIM_IDX_BITS:1];

   always_comb begin
      logic [SITE_BITS-1:0] sum_weight;
      logic [SITE_BITS-1:0] dif_weight;
      logic [SITE_BITS-1:0] sum_wrap;
      logic [SITE_BITS-1:0] dif_wrap;
      sum_weight = cur_ff.base + cfg.weight[dim];
      dif_weight = cur_ff.base - cfg.weight[dim];
      sum_wrap   = cur_ff.base + cfg.wrap[dim];
      dif_wrap   = cur_ff.base - cfg.wrap[dim];
      value_in   = HOP_VALUE;
      if (slot_ff == '0) begin
         column_in = cur_ff.site;
         value_in  = cur_ff.potential;
      end else if (!slot_m1[0]) begin
         column_in = cur_ff.at_low[dim] ? sum_wrap : dif_weight;
      end else begin
         column_in = cur_ff.at_high[dim] ? dif_wrap : sum_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            cur_valid_ff <= in_valid;
         end
         if (out_load) begin
            slot_ff <= cur_last ? '0 : slot_ff + SLOT_BITS'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= in_item;
      end
      if (out_load) begin
         column_ff   <= column_in;
         value_ff    <= value_in;
         rsp_slot_ff <= slot_ff;
         row_end_ff  <= cur_ff.row_end;
         last_ff     <= cur_last;
         bad_ff      <= cur_ff.bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = column_ff;
   assign rsp_entry_value = value_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_row_end     = row_end_ff;
   assign rsp_last        = last_ff;
   assign rsp_bad_site    = bad_ff;

endmodule

// ----- rtl/periodic_lattice_neighbor_rows_top.sv -----
// Periodic lattice neighbor row generator. One request names a lattice site
// and its on-site potential; the block returns that site's CSR matrix row.
//
// Usage: a request (req_site, req_potential) is taken when req_valid is high
// and req_stall is low. Each request yields 2*dimension_count+1 responses:
// the diagonal entry first, then the minus and plus neighbor of each
// dimension in turn, with rsp_last on the final one. rsp_row_end and
// rsp_bad_site are the same on every entry of a row.
// Configuration is written through csr_write/csr_index/csr_data while no
// request is in flight; out-of-range values are clamped.
// A request passes through a 20-stage coordinate divider, a 5-stage
// recomposition and a serializer with an output register before the first
// response of its row appears.
// Throughput: one response per cycle while rsp_stall is low, so a site takes
// 2*dimension_count+1 (3 to 9) responses, paced by the serializer; requests may be
// taken every cycle while the pipeline has room.
// Reset (synchronous) empties the pipeline and sets one dimension of side 16.
// While rsp_stall is high the response holds and the pipeline backs up into
// req_stall; nothing is lost or repeated.
module periodic_lattice_neighbor_rows_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [plnr_pkg::SITE_BITS-1:0]         req_site,
   input  logic signed [plnr_pkg::POT_BITS-1:0]   req_potential,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [plnr_pkg::SITE_BITS-1:0]         rsp_column,
   output logic signed [plnr_pkg::POT_BITS-1:0]   rsp_entry_value,
   output logic [plnr_pkg::SLOT_BITS-1:0]         rsp_slot,
   output logic [plnr_pkg::ROW_END_BITS-1:0]      rsp_row_end,
   output logic                                   rsp_last,
   output logic                                   rsp_bad_site,
   input  logic                                   csr_write,
   input  logic [plnr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [plnr_pkg::SIDE_BITS-1:0]         csr_data
);
   import plnr_pkg::*;

   cfg_type   cfg;
   logic      advance;
   logic      div_valid;
   coord_type div_item;
   logic      cmp_valid;
   item_type  cmp_item;

   assign req_stall = !advance;

   plnr_config u_config (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   plnr_divider u_divider (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_valid),
      .req_site      (req_site),
      .req_potential (req_potential),
      .cfg           (cfg),
      .out_valid     (div_valid),
      .out_item      (div_item)
   );

   plnr_compose u_compose (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg),
      .in_valid  (div_valid),
      .in_item   (div_item),
      .out_valid (cmp_valid),
      .out_item  (cmp_item)
   );

   plnr_emitter u_emitter (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (cmp_valid),
      .in_item         (cmp_item),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column      (rsp_column),
      .rsp_entry_value (rsp_entry_value),
      .rsp_slot        (rsp_slot),
      .rsp_row_end     (rsp_row_end),
      .rsp_last        (rsp_last),
      .rsp_bad_site    (rsp_bad_site)
   );

endmodule

// ----- sim/periodic_lattice_neighbor_rows_top_tb.sv -----
// Testbench for periodic_lattice_neighbor_rows_top: drives site requests under
// several lattice settings and checks every CSR row entry against its own row
// predictor. Depends on rtl/plnr_pkg.sv and the block's RTL.
module periodic_lattice_neighbor_rows_top_tb;
   import plnr_pkg::*;

   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 40;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SITE_SPAN   = 1 << SITE_BITS;

   typedef struct {
      logic [SITE_BITS-1:0]        column;
      logic signed [POT_BITS-1:0]  entry_value;
      logic [SLOT_BITS-1:0]        slot;
      logic [ROW_END_BITS-1:0]     row_end;
      logic                        last;
      logic                        bad_site;
   } row_entry_type;

   class row_scoreboard_type;
      row_entry_type expected_entries[$];
      int unsigned dims_reg = DIMS_RESET;
      int unsigned side_reg = SIDE_RESET;
      int errors;
      int checked;

      function void set_lattice(logic [SIDE_BITS-1:0] dims_data,
                                logic [SIDE_BITS-1:0] side_data);
         dims_reg = dims_data[DIM_BITS-1:0];
         side_reg = side_data;
      endfunction

      function int unsigned used_dims();
         if (dims_reg < 1) return 1;
         if (dims_reg > MAX_DIMS) return MAX_DIMS;
         return dims_reg;
      endfunction

      function longint unsigned used_side();
         if (side_reg < 1) return 1;
         if (side_reg > SIDE_MAX) return SIDE_MAX;
         return side_reg;
      endfunction

      function longint unsigned lattice_size();
         longint unsigned total;
         total = 1;
         for (int d = 0; d < used_dims(); d++) total *= used_side();
         return total;
      endfunction

      // Builds the full row for one site: diagonal first, then the minus and
      // plus neighbors of each dimension, with periodic wrap on each digit.
      function void note_site(logic [SITE_BITS-1:0] site, logic [POT_BITS-1:0] pot);
         int unsigned dims;
         longint unsigned side, rest, total, col, nc, row_end;
         longint unsigned coord[MAX_DIMS];
         longint unsigned weight[MAX_DIMS];
         int count;
         int n;
         row_entry_type ent;
         dims = used_dims();
         side = used_side();
         rest = site;
         total = 1;
         for (int d = 0; d < dims; d++) begin
            weight[d] = total;
            coord[d] = rest % side;
            rest = rest / side;
            total *= side;
         end
         count = 2 * dims + 1;
         rest = site;
         row_end = (rest + 1) * count;
         ent.row_end = row_end[ROW_END_BITS-1:0];
         ent.bad_site = (rest >= total);
         ent.column = site;
         ent.entry_value = pot;
         ent.slot = '0;
         ent.last = (count == 1);
         expected_entries = {expected_entries, ent};
         n = 1;
         for (int d = 0; d < dims; d++) begin
            for (int s = 0; s < 2; s++) begin
               nc = (s == 0) ? (coord[d] + side - 1) % side : (coord[d] + 1) % side;
               col = 0;
               for (int e = 0; e < dims; e++) col += ((e == d) ? nc : coord[e]) * weight[e];
               ent.column = col[SITE_BITS-1:0];
               ent.entry_value = HOP_VALUE;
               ent.slot = SLOT_BITS'(1 + 2 * d + s);
               ent.last = (n + 1 == count);
               expected_entries = {expected_entries, ent};
               n++;
            end
         end
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_entry(row_entry_type got);
         row_entry_type want;
         if (expected_entries.size() == 0) begin
            report($sformatf("unexpected entry column %0d slot %0d", got.column, got.slot));
            return;
         end
         want = expected_entries.pop_front();
         checked++;
         if (got.column !== want.column)
            report($sformatf("column %0d, want %0d (slot %0d, row end %0d)",
                             got.column, want.column, want.slot, want.row_end));
         if (got.entry_value !== want.entry_value)
            report($sformatf("entry_value %0d, want %0d", got.entry_value, want.entry_value));
         if (got.slot !== want.slot)
            report($sformatf("slot %0d, want %0d", got.slot, want.slot));
         if (got.row_end !== want.row_end)
            report($sformatf("row_end %0d, want %0d", got.row_end, want.row_end));
         if (got.last !== want.last)
            report($sformatf("last %0b, want %0b (slot %0d)", got.last, want.last, want.slot));
         if (got.bad_site !== want.bad_site)
            report($sformatf("bad_site %0b, want %0b", got.bad_site, want.bad_site));
      endtask
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [SITE_BITS-1:0]         req_site;
   logic signed [POT_BITS-1:0]   req_potential;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [SITE_BITS-1:0]         rsp_column;
   logic signed [POT_BITS-1:0]   rsp_entry_value;
   logic [SLOT_BITS-1:0]         rsp_slot;
   logic [ROW_END_BITS-1:0]      rsp_row_end;
   logic                         rsp_last;
   logic                         rsp_bad_site;
   logic                         csr_write;
   logic [CSR_INDEX_BITS-1:0]    csr_index;
   logic [SIDE_BITS-1:0]         csr_data;

   row_scoreboard_type sb;
   bit steady_flow;
   bit hold_responses;
   int idle_cycles;
   int requests_sent;
   int settings_used;

   periodic_lattice_neighbor_rows_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_site        (req_site),
      .req_potential   (req_potential),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column      (rsp_column),
      .rsp_entry_value (rsp_entry_value),
      .rsp_slot        (rsp_slot),
      .rsp_row_end     (rsp_row_end),
      .rsp_last        (rsp_last),
      .rsp_bad_site    (rsp_bad_site),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      row_entry_type got;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            got.column = rsp_column;
            got.entry_value = rsp_entry_value;
            got.slot = rsp_slot;
            got.row_end = rsp_row_end;
            got.last = rsp_last;
            got.bad_site = rsp_bad_site;
            sb.check_entry(got);
         end
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("No progress for %0d cycles.", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int n;
      bit held;
      held = 0;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_responses && !held) begin
            n = LONG_HOLD;
            held = 1;
         end else begin
            n = steady_flow ? 0 : $urandom_range(0, 4);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   task automatic send_site(input logic [SITE_BITS-1:0] site,
                            input logic [POT_BITS-1:0] pot);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_site <= site;
      req_potential <= pot;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_site(site, pot);
      requests_sent++;
   endtask

   task automatic drain_rows();
      req_valid <= 1'b0;
      while (sb.expected_entries.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_lattice(input logic [SIDE_BITS-1:0] dims_data,
                                input logic [SIDE_BITS-1:0] side_data);
      csr_write <= 1'b1;
      csr_index <= CSR_DIMENSION_COUNT;
      csr_data <= dims_data;
      @(posedge clock);
      csr_index <= CSR_SIDE_LENGTH;
      csr_data <= side_data;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_lattice(dims_data, side_data);
      settings_used++;
   endtask

   task automatic send_random_sites(input int count);
      longint unsigned total;
      int unsigned lim;
      int unsigned pick;
      logic [SITE_BITS-1:0] site;
      total = sb.lattice_size();
      lim = (total > SITE_SPAN) ? SITE_SPAN : 32'(total);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) site = SITE_BITS'($urandom_range(0, lim - 1));
         else if (pick == 8 && lim < SITE_SPAN)
            site = SITE_BITS'($urandom_range(lim, SITE_SPAN - 1));
         else site = SITE_BITS'($urandom);
         send_site(site, POT_BITS'($urandom));
      end
   endtask

   initial begin
      logic [SIDE_BITS-1:0] dims_data;
      logic [SIDE_BITS-1:0] side_data;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_site <= '0;
      req_potential <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_DIMENSION_COUNT;
      csr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset lattice: one dimension of 16 sites, edges and sites past the end.
      send_site(20'd0, 16'sd0);
      send_site(20'd15, 16'sd32767);
      send_site(20'd16, -16'sd32768);
      send_site(20'hFFFFF, 16'sd4096);
      drain_rows();

      // Largest lattice; recomposed columns overflow the site width.
      write_lattice(11'd4, 11'd1024);
      send_site(20'd0, -16'sd1);
      send_site(20'd1023, 16'sd1);
      send_site(20'hFFFFF, -16'sd32768);
      send_site(20'd1048064, 16'sd32767);
      drain_rows();

      // Zero values fall back to a single site in one dimension.
      write_lattice(11'h408, 11'd0);
      send_site(20'd0, 16'sd100);
      send_site(20'd1, -16'sd100);
      drain_rows();

      // Out-of-range values clamp to four dimensions of 1024 sites.
      write_lattice(11'd7, 11'd2047);
      send_site(20'd5, 16'sd2048);
      send_site(20'd1024, -16'sd4096);
      drain_rows();

      // Side of two: minus and plus neighbors coincide.
      write_lattice(11'd2, 11'd2);
      send_site(20'd0, 16'sd7);
      send_site(20'd3, 16'sd8);
      send_site(20'd4, 16'sd9);
      drain_rows();

      write_lattice(11'd3, 11'd1);
      send_site(20'd0, 16'sd11);
      send_site(20'd2, 16'sd12);
      drain_rows();

      for (int p = 0; p < 6; p++) begin
         dims_data = (p == 4) ? SIDE_BITS'($urandom_range(0, 2047))
                              : SIDE_BITS'($urandom_range(1, 4));
         case (p % 3)
            0: side_data = SIDE_BITS'($urandom_range(1, 6));
            1: side_data = SIDE_BITS'($urandom_range(7, 1024));
            default: side_data = SIDE_BITS'($urandom_range(0, 2047));
         endcase
         write_lattice(dims_data, side_data);
         steady_flow = (p == 3);
         hold_responses = (p == 1);
         send_random_sites(22);
         drain_rows();
         steady_flow = 0;
      end

      $display("Checked %0d row entries from %0d site requests over %0d lattice settings,",
               sb.checked, requests_sent, settings_used);
      $display("including clamped registers, sites past the lattice and a long output stall.");
      if (sb.errors == 0 && sb.expected_entries.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
